@@ hw/rtl/pcc_pkg.sv @@
package pcc_pkg;

	// Fixed field widths
	localparam int POS_W = 6;
	localparam int VAL_W = 6;
	localparam int CNT_W = 7;
	// Positions at or above this cannot be carried by the position field
	localparam int POS_SPAN = 2 ** POS_W;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_en;        // store an accepted word
		logic start_count;  // latch size, clear marks, tally, error and start index
		logic rd_start;     // read both maps at the start index
		logic chk;          // fold the start entry into the range error
		logic mark_t;       // mark the start entry and count a new cycle
		logic rd_second;    // read second map at the first image
		logic mark_img;     // mark the composed image
		logic rd_first;     // read first map at the composed image
		logic next_t;       // advance the start index
		logic emit;         // load the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic t_end;     // start index reached the size
		logic vis_t;     // start entry already marked
		logic mid_oob;   // first image at or beyond size
		logic img_oob;   // composed image at or beyond size
		logic vis_img;   // composed image already marked
		logic out_busy;  // output register holds a word that is not taken
	} sts_t;

endpackage

@@ hw/rtl/pcc_dpath.sv @@
module pcc_dpath import pcc_pkg::*; #(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [POS_W-1:0] position,
	input  logic [VAL_W-1:0] first_value,
	input  logic [VAL_W-1:0] second_value,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [CNT_W-1:0] cycle_count,
	output logic             range_error
);

	localparam int SD = (MAX_SYMBOLS < POS_SPAN) ? MAX_SYMBOLS : POS_SPAN;
	localparam int AW = $clog2(SD);
	localparam logic [CNT_W-1:0] SD_C = CNT_W'(SD);

	logic [VAL_W-1:0] first_mem [SD];
	logic [VAL_W-1:0] second_mem [SD];

	logic [VAL_W-1:0] first_rd_q;
	logic [VAL_W-1:0] second_rd_q;
	logic [CNT_W-1:0] size_q;
	logic [CNT_W-1:0] t_q;
	logic [CNT_W-1:0] tally_q;
	logic             err_q;
	logic [SD-1:0]    visited_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] cycle_count_q;
	logic             range_error_q;

	logic [AW-1:0]    waddr;
	logic [AW-1:0]    t_idx;
	logic [AW-1:0]    img_idx;
	logic [AW-1:0]    mid_idx;
	logic [AW-1:0]    first_raddr;
	logic [AW-1:0]    second_raddr;
	logic [CNT_W-1:0] pos_ext;
	logic [CNT_W-1:0] new_size;
	logic             pos_in_range;

	assign pos_ext      = CNT_W'(position);
	assign pos_in_range = pos_ext < SD_C;
	assign new_size     = pos_in_range ? pos_ext + 1'b1 : SD_C;
	assign waddr        = AW'(position);
	assign t_idx        = AW'(t_q);
	assign img_idx      = AW'(second_rd_q);
	assign mid_idx      = AW'(first_rd_q);
	assign first_raddr  = cmd.rd_first ? img_idx : t_idx;
	assign second_raddr = cmd.rd_second ? mid_idx : t_idx;

	// Map storage, one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.wr_en && pos_in_range) begin
			first_mem[waddr]  <= first_value;
			second_mem[waddr] <= second_value;
		end
		if (cmd.rd_start || cmd.rd_first) begin
			first_rd_q <= first_mem[first_raddr];
		end
		if (cmd.rd_start || cmd.rd_second) begin
			second_rd_q <= second_mem[second_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= '0;
			t_q       <= '0;
			tally_q   <= '0;
			err_q     <= 1'b0;
			visited_q <= '0;
		end else begin
			if (cmd.start_count) begin
				size_q    <= new_size;
				t_q       <= '0;
				tally_q   <= '0;
				err_q     <= 1'b0;
				visited_q <= '0;
			end
			if (cmd.chk) begin
				err_q <= err_q | (CNT_W'(first_rd_q) >= size_q)
					| (CNT_W'(second_rd_q) >= size_q);
			end
			if (cmd.mark_t) begin
				visited_q[t_idx] <= 1'b1;
				tally_q          <= tally_q + 1'b1;
			end
			if (cmd.mark_img) begin
				visited_q[img_idx] <= 1'b1;
			end
			if (cmd.next_t) begin
				t_q <= t_q + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cycle_count_q <= tally_q;
			range_error_q <= err_q;
		end
	end

	assign sts.t_end    = t_q == size_q;
	assign sts.vis_t    = visited_q[t_idx];
	assign sts.mid_oob  = CNT_W'(first_rd_q) >= size_q;
	assign sts.img_oob  = CNT_W'(second_rd_q) >= size_q;
	assign sts.vis_img  = visited_q[img_idx];
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign cycle_count = cycle_count_q;
	assign range_error = range_error_q;

endmodule

@@ hw/rtl/pcc_ctrl.sv @@
module pcc_ctrl import pcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_SEC   = 3'd3;
	localparam logic [2:0] ST_FIRST = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.wr_en  = in_valid;
				if (in_valid && last) begin
					cmd.start_count = 1'b1;
					state_d         = ST_START;
				end
			end
			ST_START: begin
				if (sts.t_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.rd_start = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.chk = 1'b1;
				if (sts.vis_t) begin
					cmd.next_t = 1'b1;
					state_d    = ST_START;
				end else begin
					cmd.mark_t = 1'b1;
					if (sts.mid_oob) begin
						cmd.next_t = 1'b1;
						state_d    = ST_START;
					end else begin
						cmd.rd_second = 1'b1;
						state_d       = ST_SEC;
					end
				end
			end
			ST_SEC: begin
				if (sts.img_oob || sts.vis_img) begin
					cmd.next_t = 1'b1;
					state_d    = ST_START;
				end else begin
					cmd.mark_img = 1'b1;
					cmd.rd_first = 1'b1;
					state_d      = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (sts.mid_oob) begin
					cmd.next_t = 1'b1;
					state_d    = ST_START;
				end else begin
					cmd.rd_second = 1'b1;
					state_d       = ST_SEC;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/permutation_compose_cycle_count.sv @@
// Permutation compose and cycle count. Stream in map entries one word each
// (position, first_value, second_value); the word marked last fixes the size
// at its position plus one, capped at MAX_SYMBOLS. On that word the block
// composes the maps left to right (entry t becomes second[first[t]]) and
// counts the cycles of the result, then delivers one word with cycle_count
// and range_error. range_error flags any loaded value at or beyond the size;
// a walk step that leaves the range ends that walk. Words load only while the
// block is idle. The count runs as a sequencer over one read port per map:
// each start position passes through a start and a check state, and each
// walked entry through a second-map and a first-map read state. No input is
// taken from the last word until the result is loaded. The result sits in an
// output register, so new entries load while it waits; a following count
// holds at its end until that register is free. Entries keep their contents
// across counts; entries never written read back as unknown values.
module permutation_compose_cycle_count import pcc_pkg::*; #(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [POS_W-1:0] position,
	input  logic [VAL_W-1:0] first_value,
	input  logic [VAL_W-1:0] second_value,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CNT_W-1:0] cycle_count,
	output logic             range_error
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer: load, scan starts, walk, deliver
	pcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Map stores, visit marks, counters and output register
	pcc_dpath #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.position     (position),
		.first_value  (first_value),
		.second_value (second_value),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.cycle_count  (cycle_count),
		.range_error  (range_error)
	);

	// Never overwrite a result word that is still waiting
	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && !out_ready))
		else $error("result overwritten while pending");

	// A loaded result is presented on the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("result not presented after emit");

	// Hold off input once a count starts
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_count |=> !in_ready)
		else $error("input taken during count");

endmodule
